[rtl/gbn_pkg.sv]
// gbn_pkg: shared types and codes for the go-back-n sequence controller
// no dependencies; imported by gbn_front, gbn_back and the top level

package gbn_pkg;

    // link event codes on the command port
    localparam logic [1:0] CMD_PACKET  = 2'd0;
    localparam logic [1:0] CMD_PHY_RDY = 2'd1;
    localparam logic [1:0] CMD_FRAME   = 2'd2;
    localparam logic [1:0] CMD_TIMEOUT = 2'd3;

    // received frame kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_NAK  = 2'd2;

    localparam int ACTION_BITS = 3;

    // result actions
    typedef enum logic [ACTION_BITS-1:0] {
        ACT_NONE    = 3'd0,
        ACT_SEND    = 3'd1,
        ACT_NAK     = 3'd2,
        ACT_DELIVER = 3'd3,
        ACT_STOP    = 3'd4
    } action_t;

    // classified operations passed from front to back
    typedef enum logic [2:0] {
        OP_PACKET,
        OP_PHY_RDY,
        OP_BAD_FRAME,
        OP_RESEND,
        OP_DATA_FRAME,
        OP_ACK_FRAME
    } op_t;

    localparam int OP_BITS = $bits(op_t);

endpackage

[rtl/gbn_queue.sv]
// gbn_queue: two-entry first-in first-out queue with registered storage
// no dependencies; generic in word width

module gbn_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage needs no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[rtl/gbn_front.sv]
// gbn_front: input register stage that takes link events and classifies them
// depends on gbn_pkg for event, frame kind and operation codes

module gbn_front #(
    parameter int SEQ_BITS = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          command,
    input  logic                frame_good,
    input  logic [1:0]          frame_type,
    input  logic [SEQ_BITS-1:0] frame_num,
    input  logic [SEQ_BITS-1:0] frame_ack,
    output logic                op_push,
    output gbn_pkg::op_t        op_kind,
    output logic [SEQ_BITS-1:0] op_seq,
    output logic [SEQ_BITS-1:0] op_ack,
    input  logic                op_full
);
    import gbn_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    op_t                 kind_reg;
    op_t                 kind_next;
    logic [SEQ_BITS-1:0] seq_reg;
    logic [SEQ_BITS-1:0] ack_reg;
    logic                take;

    assign full    = valid_reg && op_full;
    assign take    = push && !full;
    assign op_push = valid_reg && !op_full;
    assign op_kind = kind_reg;
    assign op_seq  = seq_reg;
    assign op_ack  = ack_reg;

    // classify the event
    always_comb
    begin
        case (command)
            CMD_PACKET:  kind_next = OP_PACKET;
            CMD_PHY_RDY: kind_next = OP_PHY_RDY;
            CMD_FRAME:
            begin
                if (!frame_good)
                begin
                    kind_next = OP_BAD_FRAME;
                end
                else if (frame_type == KIND_NAK)
                begin
                    kind_next = OP_RESEND;
                end
                else if (frame_type == KIND_DATA)
                begin
                    kind_next = OP_DATA_FRAME;
                end
                else
                begin
                    // ack kind and the unused kind both carry only an ack
                    kind_next = OP_ACK_FRAME;
                end
            end
            CMD_TIMEOUT: kind_next = OP_RESEND;
            default:     kind_next = OP_RESEND;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (op_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg <= kind_next;
            seq_reg  <= frame_num;
            ack_reg  <= frame_ack;
        end
    end

endmodule

[rtl/gbn_back.sv]
// gbn_back: sequencer that holds the window state and emits action runs
// depends on gbn_pkg for operation and action codes

module gbn_back #(
    parameter int SEQ_BITS = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                op_valid,
    input  gbn_pkg::op_t        op_kind,
    input  logic [SEQ_BITS-1:0] op_seq,
    input  logic [SEQ_BITS-1:0] op_ack,
    output logic                op_pop,
    input  logic                out_full,
    output logic                out_push,
    output gbn_pkg::action_t    out_action,
    output logic [SEQ_BITS-1:0] out_seq,
    output logic [SEQ_BITS-1:0] out_ack,
    output logic                out_net_en,
    output logic                out_last
);
    import gbn_pkg::*;

    localparam logic [SEQ_BITS-1:0] WIN_MAX = '1;
    localparam logic [SEQ_BITS-1:0] ONE     = {{(SEQ_BITS-1){1'b0}}, 1'b1};

    typedef enum logic [1:0] {
        S_IDLE,
        S_RESEND,
        S_ACK
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [SEQ_BITS-1:0] oldest_reg;
    logic [SEQ_BITS-1:0] oldest_next;
    logic [SEQ_BITS-1:0] nts_reg;
    logic [SEQ_BITS-1:0] nts_next;
    logic [SEQ_BITS-1:0] exp_reg;
    logic [SEQ_BITS-1:0] exp_next;
    logic [SEQ_BITS-1:0] count_reg;
    logic [SEQ_BITS-1:0] count_next;
    logic                nak_ok_reg;
    logic                nak_ok_next;
    logic                phy_reg;
    logic                phy_next;
    logic [SEQ_BITS-1:0] rem_reg;
    logic [SEQ_BITS-1:0] rem_next;
    logic [SEQ_BITS-1:0] tgt_reg;
    logic [SEQ_BITS-1:0] tgt_next;
    logic                win_now;
    logic                win_step;

    // b lies in the circular window [a, c)
    function automatic logic in_window(
        input logic [SEQ_BITS-1:0] a,
        input logic [SEQ_BITS-1:0] b,
        input logic [SEQ_BITS-1:0] c
    );
        in_window = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) ||
                    ((b < c) && (c < a));
    endfunction

    assign win_now  = in_window(oldest_reg, op_ack, nts_reg);
    assign win_step = in_window(oldest_reg + ONE, tgt_reg, nts_reg);
    assign out_ack  = exp_reg - ONE;
    assign out_net_en = out_last && (count_next < WIN_MAX) && phy_next;

    always_comb
    begin
        state_next  = state_reg;
        oldest_next = oldest_reg;
        nts_next    = nts_reg;
        exp_next    = exp_reg;
        count_next  = count_reg;
        nak_ok_next = nak_ok_reg;
        phy_next    = phy_reg;
        rem_next    = rem_reg;
        tgt_next    = tgt_reg;
        op_pop      = 1'b0;
        out_push    = 1'b0;
        out_action  = ACT_NONE;
        out_seq     = '0;
        out_last    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (op_valid && !out_full)
                begin
                    op_pop = 1'b1;
                    case (op_kind)
                        OP_PACKET:
                        begin
                            out_push = 1'b1;
                            out_last = 1'b1;
                            if (count_reg < WIN_MAX)
                            begin
                                out_action = ACT_SEND;
                                out_seq    = nts_reg;
                                count_next = count_reg + ONE;
                                nts_next   = nts_reg + ONE;
                                phy_next   = 1'b0;
                            end
                        end
                        OP_PHY_RDY:
                        begin
                            phy_next = 1'b1;
                            out_push = 1'b1;
                            out_last = 1'b1;
                        end
                        OP_BAD_FRAME:
                        begin
                            out_push = 1'b1;
                            out_last = 1'b1;
                            if (nak_ok_reg)
                            begin
                                out_action  = ACT_NAK;
                                out_seq     = exp_reg;
                                nak_ok_next = 1'b0;
                                phy_next    = 1'b0;
                            end
                        end
                        OP_RESEND:
                        begin
                            nts_next = oldest_reg;
                            if (count_reg == '0)
                            begin
                                out_push = 1'b1;
                                out_last = 1'b1;
                            end
                            else
                            begin
                                rem_next   = count_reg;
                                state_next = S_RESEND;
                            end
                        end
                        OP_DATA_FRAME:
                        begin
                            tgt_next = op_ack;
                            if (op_seq == exp_reg)
                            begin
                                out_push    = 1'b1;
                                out_last    = !win_now;
                                out_action  = ACT_DELIVER;
                                out_seq     = op_seq;
                                nak_ok_next = 1'b1;
                                exp_next    = exp_reg + ONE;
                            end
                            else if (nak_ok_reg)
                            begin
                                out_push    = 1'b1;
                                out_last    = !win_now;
                                out_action  = ACT_NAK;
                                out_seq     = exp_reg;
                                nak_ok_next = 1'b0;
                                phy_next    = 1'b0;
                            end
                            else if (!win_now)
                            begin
                                out_push = 1'b1;
                                out_last = 1'b1;
                            end
                            if (win_now)
                            begin
                                state_next = S_ACK;
                            end
                        end
                        OP_ACK_FRAME:
                        begin
                            tgt_next = op_ack;
                            if (win_now)
                            begin
                                state_next = S_ACK;
                            end
                            else
                            begin
                                out_push = 1'b1;
                                out_last = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_push = 1'b1;
                            out_last = 1'b1;
                        end
                    endcase
                end
            end
            S_RESEND:
            begin
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    out_action = ACT_SEND;
                    out_seq    = nts_reg;
                    out_last   = (rem_reg == ONE);
                    nts_next   = nts_reg + ONE;
                    phy_next   = 1'b0;
                    rem_next   = rem_reg - ONE;
                    if (rem_reg == ONE)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ACK:
            begin
                if (!out_full)
                begin
                    out_push    = 1'b1;
                    out_action  = ACT_STOP;
                    out_seq     = oldest_reg;
                    out_last    = !win_step;
                    oldest_next = oldest_reg + ONE;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - ONE;
                    end
                    if (!win_step)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            oldest_reg <= '0;
            nts_reg    <= '0;
            exp_reg    <= '0;
            count_reg  <= '0;
            nak_ok_reg <= 1'b1;
            phy_reg    <= 1'b0;
            rem_reg    <= '0;
            tgt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            oldest_reg <= oldest_next;
            nts_reg    <= nts_next;
            exp_reg    <= exp_next;
            count_reg  <= count_next;
            nak_ok_reg <= nak_ok_next;
            phy_reg    <= phy_next;
            rem_reg    <= rem_next;
            tgt_reg    <= tgt_next;
        end
    end

endmodule

[rtl/go_back_n_arq_controller.sv]
// go_back_n_arq_controller: top level of the go-back-n sequence controller
// depends on gbn_pkg, gbn_front, gbn_queue and gbn_back
//
// usage
// - input side is a queue: an event transfers on a rising edge with push high
//   and full low; command picks packet ready, physical layer ready, frame
//   received (with frame_good, frame_type, frame_num, frame_ack) or timeout
// - result side is a queue: the oldest result sits on action, seq, ack,
//   network_enable and last while empty is low, and transfers with pop high
// - every event yields a run of one or more results; last marks the final
//   one, which alone carries network_enable
// - the first result of a run passes the front register, the op queue and
//   the result queue; a resend run or a run of stop-timer results with no
//   deliver or nak ahead of it also waits on a sequencer state change
// - throughput: the sequencer emits one result a cycle while the result
//   queue is not full, and takes the next event only after a run ends; the
//   worst case is a deliver or nak followed by 2^SEQ_BITS - 1 stop results
// - reset clears both queues and the window state: pointers and count to
//   zero, one nak allowed, physical layer not ready
// - a stalled result side fills the result queue and freezes the sequencer;
//   the op queue and front register then fill and full rises

module go_back_n_arq_controller #(
    parameter int SEQ_BITS = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    // event side
    input  logic                push,
    output logic                full,
    input  logic [1:0]          command,
    input  logic                frame_good,
    input  logic [1:0]          frame_type,
    input  logic [SEQ_BITS-1:0] frame_num,
    input  logic [SEQ_BITS-1:0] frame_ack,
    // result side
    output logic                empty,
    input  logic                pop,
    output logic [2:0]          action,
    output logic [SEQ_BITS-1:0] seq,
    output logic [SEQ_BITS-1:0] ack,
    output logic                network_enable,
    output logic                last
);
    import gbn_pkg::*;

    // op queue word: operation, frame sequence, frame ack
    localparam int OPQ_W = OP_BITS + 2 * SEQ_BITS;
    // result queue word: action, seq, ack, network enable, last
    localparam int RES_W = ACTION_BITS + 2 * SEQ_BITS + 2;

    // front to op queue
    logic                fr_push;
    op_t                 fr_kind;
    logic [SEQ_BITS-1:0] fr_seq;
    logic [SEQ_BITS-1:0] fr_ack;
    logic                opq_full;
    logic [OPQ_W-1:0]    opq_wdata;

    // op queue to back
    logic [OPQ_W-1:0]    opq_rdata;
    logic                opq_empty;
    logic                bk_pop;
    op_t                 bk_kind;
    logic [SEQ_BITS-1:0] bk_seq;
    logic [SEQ_BITS-1:0] bk_ack;

    // back to result queue
    logic                res_full;
    logic                res_push;
    action_t             res_action;
    logic [SEQ_BITS-1:0] res_seq;
    logic [SEQ_BITS-1:0] res_ack;
    logic                res_net_en;
    logic                res_last;
    logic [RES_W-1:0]    res_wdata;
    logic [RES_W-1:0]    res_rdata;

    // event classification and input register
    gbn_front #(
        .SEQ_BITS (SEQ_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .frame_good (frame_good),
        .frame_type (frame_type),
        .frame_num  (frame_num),
        .frame_ack  (frame_ack),
        .op_push    (fr_push),
        .op_kind    (fr_kind),
        .op_seq     (fr_seq),
        .op_ack     (fr_ack),
        .op_full    (opq_full)
    );

    assign opq_wdata = {fr_kind, fr_seq, fr_ack};

    // decoupling queue between classification and sequencing
    gbn_queue #(
        .WIDTH (OPQ_W)
    ) u_op_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fr_push),
        .wr_data (opq_wdata),
        .full    (opq_full),
        .rd_en   (bk_pop),
        .rd_data (opq_rdata),
        .empty   (opq_empty)
    );

    assign bk_kind = op_t'(opq_rdata[OPQ_W-1 -: OP_BITS]);
    assign bk_seq  = opq_rdata[2*SEQ_BITS-1 -: SEQ_BITS];
    assign bk_ack  = opq_rdata[SEQ_BITS-1:0];

    // window state and action runs
    gbn_back #(
        .SEQ_BITS (SEQ_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (!opq_empty),
        .op_kind    (bk_kind),
        .op_seq     (bk_seq),
        .op_ack     (bk_ack),
        .op_pop     (bk_pop),
        .out_full   (res_full),
        .out_push   (res_push),
        .out_action (res_action),
        .out_seq    (res_seq),
        .out_ack    (res_ack),
        .out_net_en (res_net_en),
        .out_last   (res_last)
    );

    assign res_wdata = {res_action, res_seq, res_ack, res_net_en, res_last};

    // result queue keeps the sequencer running while a result waits
    gbn_queue #(
        .WIDTH (RES_W)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_wdata),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rdata),
        .empty   (empty)
    );

    assign action         = res_rdata[RES_W-1 -: ACTION_BITS];
    assign seq            = res_rdata[2*SEQ_BITS+1 -: SEQ_BITS];
    assign ack            = res_rdata[SEQ_BITS+1 -: SEQ_BITS];
    assign network_enable = res_rdata[1];
    assign last           = res_rdata[0];

endmodule
